// ===== rtl/bllh_pkg.sv =====
// Package for the battery level lamp driver.
// Holds sample widths, level and lamp codes, threshold reset values and the shared types.
// No dependencies.
package bllh_pkg;

  // ADC resolution; the input word carries one more bit for the supply marker
  localparam int SAMPLE_BITS = 12;
  localparam int INPUT_BITS  = SAMPLE_BITS + 1;

  // APB data and address widths
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_REGS   = 6;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_GREEN_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_YELLOW_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YELLOW_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RED_HIGH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RED_LOW     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_HIGH  = 3'd5;

  // Threshold reset values
  localparam logic [SAMPLE_BITS-1:0] RST_GREEN_LOW   = SAMPLE_BITS'(2559);
  localparam logic [SAMPLE_BITS-1:0] RST_YELLOW_HIGH = SAMPLE_BITS'(2627);
  localparam logic [SAMPLE_BITS-1:0] RST_YELLOW_LOW  = SAMPLE_BITS'(2508);
  localparam logic [SAMPLE_BITS-1:0] RST_RED_HIGH    = SAMPLE_BITS'(2576);
  localparam logic [SAMPLE_BITS-1:0] RST_RED_LOW     = SAMPLE_BITS'(2457);
  localparam logic [SAMPLE_BITS-1:0] RST_BLINK_HIGH  = SAMPLE_BITS'(2525);

  // External supply marker: the one sample with only the top bit set
  localparam logic [INPUT_BITS-1:0] SUPPLY_MARK = INPUT_BITS'(1) << SAMPLE_BITS;

  // Level codes
  localparam logic [2:0] LVL_GREEN  = 3'd0;
  localparam logic [2:0] LVL_YELLOW = 3'd1;
  localparam logic [2:0] LVL_RED    = 3'd2;
  localparam logic [2:0] LVL_BLINK  = 3'd3;
  localparam logic [2:0] LVL_NONE   = 3'd4;

  // Lamp bit positions and patterns
  localparam int LAMP_RED_BIT    = 0;
  localparam int LAMP_GREEN_BIT  = 1;
  localparam int LAMP_YELLOW_BIT = 2;
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_RED    = 3'b001;
  localparam logic [2:0] LAMP_GREEN  = 3'b010;
  localparam logic [2:0] LAMP_YELLOW = 3'b100;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] green_low;
    logic [SAMPLE_BITS-1:0] yellow_high;
    logic [SAMPLE_BITS-1:0] yellow_low;
    logic [SAMPLE_BITS-1:0] red_high;
    logic [SAMPLE_BITS-1:0] red_low;
    logic [SAMPLE_BITS-1:0] blink_high;
  } thr_t;

  typedef struct packed {
    logic [2:0] level;
    logic       first;
    logic [2:0] lamp;
  } ind_state_t;

endpackage

// ===== rtl/battery_level_led_hysteresis_top.sv =====
// Top level of the battery level lamp driver with hysteresis.
// Depends on bllh_pkg, bllh_cfg and bllh_next.
//
// Usage:
//   Input channel carries one ADC word (sample_i); a word with only the top
//   bit set marks external supply. Output channel carries the lamp drives and
//   the level code that hold after that sample. Thresholds sit in six APB
//   registers at byte addresses 0x00..0x14; write them only while idle.
// Timing:
//   A word is registered at the input stage and its result is then registered
//   in the state/result register, which raises out_valid_o for it.
//   One word per cycle is sustained while the receiver does not hold off; the
//   compare and level update between these two registers are combinational.
// Reset:
//   Level green, lamps off, first-classification mode armed, thresholds at
//   their defaults, both pipeline stages empty.
// Stall:
//   While the receiver holds off, the result and the level state hold; one
//   more word can sit in the input stage before in_ready_o drops.
module battery_level_led_hysteresis_top import bllh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INPUT_BITS-1:0] sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  red_on_o,
  output logic                  green_on_o,
  output logic                  yellow_on_o,
  output logic [2:0]            level_o
);

  thr_t                  thr;
  ind_state_t            state_q;
  ind_state_t            state_d;
  logic                  s1_valid_q;
  logic [INPUT_BITS-1:0] s1_sample_q;
  logic                  out_valid_q;
  logic                  adv;
  logic                  in_acc;

  bllh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  bllh_next u_next (
    .sample_i (s1_sample_q),
    .thr_i    (thr),
    .cur_i    (state_q),
    .nxt_o    (state_d)
  );

  // Advance the input stage when the result slot is free or being taken
  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | adv;
  assign in_acc     = in_valid_i & in_ready_o;

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input stage word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
    end
  end

  // Update state, which doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.level <= LVL_GREEN;
      state_q.first <= 1'b1;
      state_q.lamp  <= LAMP_OFF;
      out_valid_q   <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_on_o    = state_q.lamp[LAMP_RED_BIT];
  assign green_on_o  = state_q.lamp[LAMP_GREEN_BIT];
  assign yellow_on_o = state_q.lamp[LAMP_YELLOW_BIT];
  assign level_o     = state_q.level;

endmodule

// ===== rtl/bllh_cfg.sv =====
// APB threshold register file for the battery level lamp driver.
// Depends on bllh_pkg for register indexes, widths and reset values.
module bllh_cfg import bllh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output thr_t                  thr_o
);

  thr_t                   thr_q;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   idx;
  logic [SAMPLE_BITS-1:0] wval;
  logic [SAMPLE_BITS-1:0] rval;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign wval   = pwdata[SAMPLE_BITS-1:0];
  assign pready = 1'b1;
  assign thr_o  = thr_q;

  // Write the addressed threshold; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.green_low   <= RST_GREEN_LOW;
      thr_q.yellow_high <= RST_YELLOW_HIGH;
      thr_q.yellow_low  <= RST_YELLOW_LOW;
      thr_q.red_high    <= RST_RED_HIGH;
      thr_q.red_low     <= RST_RED_LOW;
      thr_q.blink_high  <= RST_BLINK_HIGH;
    end else if (wr_en) begin
      unique case (idx)
        REG_GREEN_LOW:   thr_q.green_low   <= wval;
        REG_YELLOW_HIGH: thr_q.yellow_high <= wval;
        REG_YELLOW_LOW:  thr_q.yellow_low  <= wval;
        REG_RED_HIGH:    thr_q.red_high    <= wval;
        REG_RED_LOW:     thr_q.red_low     <= wval;
        REG_BLINK_HIGH:  thr_q.blink_high  <= wval;
        default: ;
      endcase
    end
  end

  // Read back the addressed threshold
  always_comb begin
    unique case (idx)
      REG_GREEN_LOW:   rval = thr_q.green_low;
      REG_YELLOW_HIGH: rval = thr_q.yellow_high;
      REG_YELLOW_LOW:  rval = thr_q.yellow_low;
      REG_RED_HIGH:    rval = thr_q.red_high;
      REG_RED_LOW:     rval = thr_q.red_low;
      REG_BLINK_HIGH:  rval = thr_q.blink_high;
      default:         rval = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_W-SAMPLE_BITS){1'b0}}, rval};

endmodule

// ===== rtl/bllh_next.sv =====
// Next level and lamp logic for one sample of the battery level lamp driver.
// Depends on bllh_pkg for level codes, lamp patterns and the state types.
module bllh_next import bllh_pkg::*; (
  input  logic [INPUT_BITS-1:0] sample_i,
  input  thr_t                  thr_i,
  input  ind_state_t            cur_i,
  output ind_state_t            nxt_o
);

  logic [2:0] lvl;
  logic       first;
  logic       supply;

  // Compare against zero-extended thresholds
  function automatic logic ge(input logic [INPUT_BITS-1:0] s,
                              input logic [SAMPLE_BITS-1:0] t);
    ge = s >= {1'b0, t};
  endfunction

  assign supply = (sample_i == SUPPLY_MARK);

  // Pick the new level
  always_comb begin
    first = cur_i.first;
    lvl   = cur_i.level;
    if (supply) begin
      lvl   = LVL_GREEN;
      first = 1'b1;
    end else if (cur_i.first) begin
      if (sample_i != '0) begin
        first = 1'b0;
        if (ge(sample_i, thr_i.green_low)) begin
          lvl = LVL_GREEN;
        end else if (ge(sample_i, thr_i.yellow_low)) begin
          lvl = LVL_YELLOW;
        end else if (ge(sample_i, thr_i.red_low)) begin
          lvl = LVL_RED;
        end else begin
          lvl = LVL_BLINK;
        end
      end else begin
        lvl = LVL_NONE;
      end
    end else begin
      // Tracking: drop test first, then rise test
      case (cur_i.level)
        LVL_GREEN: begin
          lvl = ge(sample_i, thr_i.green_low) ? LVL_GREEN : LVL_YELLOW;
        end
        LVL_YELLOW: begin
          if (!ge(sample_i, thr_i.yellow_low)) lvl = LVL_RED;
          else if (ge(sample_i, thr_i.yellow_high)) lvl = LVL_GREEN;
          else lvl = LVL_YELLOW;
        end
        LVL_RED: begin
          if (!ge(sample_i, thr_i.red_low)) lvl = LVL_BLINK;
          else if (ge(sample_i, thr_i.red_high)) lvl = LVL_YELLOW;
          else lvl = LVL_RED;
        end
        LVL_BLINK: begin
          lvl = ge(sample_i, thr_i.blink_high) ? LVL_RED : LVL_BLINK;
        end
        default: lvl = LVL_NONE;
      endcase
    end
  end

  // Drive lamps for the new level; undetermined holds them
  always_comb begin
    nxt_o.level = lvl;
    nxt_o.first = first;
    case (lvl)
      LVL_GREEN:  nxt_o.lamp = LAMP_GREEN;
      LVL_YELLOW: nxt_o.lamp = LAMP_YELLOW;
      LVL_RED:    nxt_o.lamp = LAMP_RED;
      LVL_BLINK:  nxt_o.lamp = {2'b00, ~cur_i.lamp[LAMP_RED_BIT]};
      default:    nxt_o.lamp = cur_i.lamp;
    endcase
  end

endmodule
